>>> src/assert_macros.svh
// Assertion macros used by the checker module.
// Clocked on clock, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define BAE_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define BAE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/bae_pkg.sv
// Package for the binary arithmetic encoder: widths, bound constants,
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package bae_pkg;

   localparam int PRECISION_BITS = 16;
   localparam int PENDING_WIDTH  = 16;
   localparam int PROB_W         = 16;
   localparam int FOLLOW_W       = 16;
   localparam int RESULT_LIMIT   = 17;
   localparam int CNT_W          = $clog2(RESULT_LIMIT + 1);
   localparam int PROD_W         = PROB_W + PRECISION_BITS;
   localparam int EXT_W          = (PENDING_WIDTH > FOLLOW_W) ? PENDING_WIDTH : FOLLOW_W;

   // stream widths: tdata fields packed from bit 0 up, padded to whole bytes
   localparam int REQ_TDATA_W = ((1 + PROB_W) + 7) / 8 * 8;
   localparam int RSP_TDATA_W = ((1 + FOLLOW_W) + 7) / 8 * 8;
   localparam int RSP_TUSER_W = 2;

   typedef logic [PRECISION_BITS-1:0] bound_type;
   typedef logic [PENDING_WIDTH-1:0]  pending_type;
   typedef logic [FOLLOW_W-1:0]       follow_type;
   typedef logic [PROB_W-1:0]         prob_type;
   typedef logic [PROD_W-1:0]         prod_type;
   typedef logic [CNT_W-1:0]          count_type;

   localparam bound_type   BOUND_MAX       = '1;
   localparam bound_type   BOUND_HALF      = BOUND_MAX >> 1;
   localparam bound_type   BOUND_QUARTER   = BOUND_HALF >> 1;
   localparam bound_type   BOUND_3QUARTERS = bound_type'(3 * BOUND_QUARTER);
   localparam bound_type   QUARTER_STEP    = BOUND_QUARTER + bound_type'(1);
   localparam pending_type PENDING_MAX     = '1;
   localparam follow_type  FOLLOW_MAX      = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SPLIT,
      ST_RENORM,
      ST_FLUSH,
      ST_ERROR
   } state_type;

   // what the next renormalization step would do
   typedef enum logic [1:0] {
      STEP_EMIT,
      STEP_SCALE,
      STEP_STOP
   } step_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic split;
      logic step;
      logic finish;
      logic flush;
      logic error;
   } ctrl_cmd_type;

   typedef struct packed {
      logic     flush;
      logic     prob_zero;
      step_type step;
      logic     hold_valid;
      logic     out_free;
   } ctrl_status_type;

   // clamp a pending count to the follow field
   function automatic follow_type sat_follow(pending_type p);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(p);
      if (ext > EXT_W'(FOLLOW_MAX)) begin
         return FOLLOW_MAX;
      end
      return ext[FOLLOW_W-1:0];
   endfunction

endpackage

>>> src/bae_ctrl.sv
// Controller state machine of the arithmetic encoder.
// Depends on bae_pkg; drives the datapath through ctrl_cmd_type.
`timescale 1ns / 1ps

module bae_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  bae_pkg::ctrl_status_type sts,
   output bae_pkg::ctrl_cmd_type    cmd
);
   import bae_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            if (sts.flush) begin
               state_in = ST_FLUSH;
            end else if (sts.prob_zero) begin
               state_in = ST_ERROR;
            end else begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_RENORM;
         end
         ST_RENORM: begin
            case (sts.step)
               STEP_EMIT: begin
                  // a held bit must move to the output register first
                  if (!sts.hold_valid || sts.out_free) begin
                     cmd.step = 1'b1;
                  end
               end
               STEP_SCALE: begin
                  cmd.step = 1'b1;
               end
               STEP_STOP: begin
                  if (sts.out_free) begin
                     cmd.finish = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_ERROR: begin
            if (sts.out_free) begin
               cmd.error = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/bae_datapath.sv
// Datapath of the arithmetic encoder: bounds, pending count, multiplier,
// held result and output register. Depends on bae_pkg.
`timescale 1ns / 1ps

module bae_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_cmd,
   input  logic                     in_bit,
   input  bae_pkg::prob_type        in_prob,
   input  bae_pkg::ctrl_cmd_type    cmd,
   output bae_pkg::ctrl_status_type sts,
   input  logic                     out_ready,
   output logic                     out_valid,
   output logic                     out_has_bit,
   output logic                     out_code_bit,
   output bae_pkg::follow_type      out_follow,
   output logic                     out_status,
   output logic                     out_last
);
   import bae_pkg::*;

   // item registers
   logic        cmd_ff, cmd_in;
   logic        sym_ff, sym_in;
   prob_type    prob_ff, prob_in;
   prod_type    prod_ff, prod_in;
   // coder state
   bound_type   low_ff, low_in;
   bound_type   high_ff, high_in;
   pending_type pend_ff, pend_in;
   count_type   emit_cnt_ff, emit_cnt_in;
   // last emitted bit, held until it is known whether it ends the item
   logic        hold_valid_ff, hold_valid_in;
   logic        hold_bit_ff, hold_bit_in;
   follow_type  hold_follow_ff, hold_follow_in;
   // output register
   logic        out_valid_ff, out_valid_in;
   logic        out_has_ff, out_has_in;
   logic        out_bit_ff, out_bit_in;
   follow_type  out_follow_ff, out_follow_in;
   logic        out_status_ff, out_status_in;
   logic        out_last_ff, out_last_in;

   bound_type   span;
   bound_type   mid;
   bound_type   low_scaled;
   bound_type   high_scaled;
   pending_type pend_inc;
   logic        top_eq;
   logic        scale_ok;
   logic        out_free;
   step_type    step_kind;

   // interval arithmetic and step decision
   always_comb begin
      span        = high_ff - low_ff;
      mid         = low_ff + prod_ff[PROD_W-1:PROB_W];
      low_scaled  = (low_ff - QUARTER_STEP) << 1;
      high_scaled = ((high_ff - QUARTER_STEP) << 1) | bound_type'(1);
      pend_inc    = (pend_ff == PENDING_MAX) ? pend_ff : pend_ff + pending_type'(1);
      top_eq      = (high_ff[PRECISION_BITS-1] == low_ff[PRECISION_BITS-1]);
      scale_ok    = (low_ff > BOUND_QUARTER) && (high_ff <= BOUND_3QUARTERS);
      out_free    = !out_valid_ff || out_ready;
      if (emit_cnt_ff == count_type'(RESULT_LIMIT)) begin
         step_kind = STEP_STOP;
      end else if (top_eq) begin
         step_kind = STEP_EMIT;
      end else if (scale_ok) begin
         step_kind = STEP_SCALE;
      end else begin
         step_kind = STEP_STOP;
      end
   end

   always_comb begin
      sts.flush      = cmd_ff;
      sts.prob_zero  = (prob_ff == '0);
      sts.step       = step_kind;
      sts.hold_valid = hold_valid_ff;
      sts.out_free   = out_free;
   end

   // next-value logic
   always_comb begin
      cmd_in         = cmd_ff;
      sym_in         = sym_ff;
      prob_in        = prob_ff;
      prod_in        = prod_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      pend_in        = pend_ff;
      emit_cnt_in    = emit_cnt_ff;
      hold_valid_in  = hold_valid_ff;
      hold_bit_in    = hold_bit_ff;
      hold_follow_in = hold_follow_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      out_has_in     = out_has_ff;
      out_bit_in     = out_bit_ff;
      out_follow_in  = out_follow_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;

      // capture the accepted transaction
      if (cmd.load) begin
         cmd_in      = in_cmd;
         sym_in      = in_bit;
         prob_in     = in_prob;
         emit_cnt_in = '0;
      end

      // split product, registered before the add
      if (cmd.mul) begin
         prod_in = PROD_W'(prob_ff) * PROD_W'(span);
      end

      // narrow the interval to the coded symbol
      if (cmd.split) begin
         if (sym_ff) begin
            low_in = mid + bound_type'(1);
         end else begin
            high_in = mid;
         end
      end

      // one renormalization step
      if (cmd.step) begin
         case (step_kind)
            STEP_EMIT: begin
               if (hold_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_has_in    = 1'b1;
                  out_bit_in    = hold_bit_ff;
                  out_follow_in = hold_follow_ff;
                  out_status_in = 1'b0;
                  out_last_in   = 1'b0;
               end
               hold_valid_in  = 1'b1;
               hold_bit_in    = high_ff[PRECISION_BITS-1];
               hold_follow_in = sat_follow(pend_ff);
               high_in        = {high_ff[PRECISION_BITS-2:0], 1'b1};
               low_in         = {low_ff[PRECISION_BITS-2:0], 1'b0};
               pend_in        = '0;
               emit_cnt_in    = emit_cnt_ff + count_type'(1);
            end
            STEP_SCALE: begin
               high_in = high_scaled;
               low_in  = low_scaled;
               pend_in = pend_inc;
            end
            default: begin
            end
         endcase
      end

      // close the item: held bit goes out as last, or an empty result
      if (cmd.finish) begin
         out_valid_in  = 1'b1;
         out_has_in    = hold_valid_ff;
         out_bit_in    = hold_valid_ff && hold_bit_ff;
         out_follow_in = hold_valid_ff ? hold_follow_ff : '0;
         out_status_in = 1'b0;
         out_last_in   = 1'b1;
         hold_valid_in = 1'b0;
      end

      // flush: final bit and return to the initial interval
      if (cmd.flush) begin
         out_valid_in  = 1'b1;
         out_has_in    = 1'b1;
         out_bit_in    = !(low_ff < BOUND_QUARTER);
         out_follow_in = sat_follow(pend_inc);
         out_status_in = 1'b0;
         out_last_in   = 1'b1;
         low_in        = '0;
         high_in       = BOUND_MAX;
         pend_in       = '0;
      end

      // zero probability: error result, state untouched
      if (cmd.error) begin
         out_valid_in  = 1'b1;
         out_has_in    = 1'b0;
         out_bit_in    = 1'b0;
         out_follow_in = '0;
         out_status_in = 1'b1;
         out_last_in   = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff        <= '0;
         high_ff       <= BOUND_MAX;
         pend_ff       <= '0;
         emit_cnt_ff   <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         low_ff        <= low_in;
         high_ff       <= high_in;
         pend_ff       <= pend_in;
         emit_cnt_ff   <= emit_cnt_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      sym_ff         <= sym_in;
      prob_ff        <= prob_in;
      prod_ff        <= prod_in;
      hold_bit_ff    <= hold_bit_in;
      hold_follow_ff <= hold_follow_in;
      out_has_ff     <= out_has_in;
      out_bit_ff     <= out_bit_in;
      out_follow_ff  <= out_follow_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

   assign out_valid    = out_valid_ff;
   assign out_has_bit  = out_has_ff;
   assign out_code_bit = out_bit_ff;
   assign out_follow   = out_follow_ff;
   assign out_status   = out_status_ff;
   assign out_last     = out_last_ff;

endmodule

>>> src/binary_arithmetic_encoder_top.sv
// Binary arithmetic encoder with 16-bit bounds and E1/E2/E3 scaling.
// An encode transaction runs a registered multiply, the interval split and
// a renormalization loop that applies one step (halving or middle scaling)
// per cycle unless a held bit waits for the output register; a flush or a
// zero-probability transaction skips the split and the loop. A result
// waiting in the output register does not hold off the next request.
// Depends on bae_pkg, bae_ctrl and bae_datapath.
`timescale 1ns / 1ps

module binary_arithmetic_encoder_top (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bae_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [0] bit_in, [16:1] prob_zero
   input  logic                                req_tuser,  // [0] cmd
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bae_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // [0] code_bit, [16:1] follow_count
   output logic [bae_pkg::RSP_TUSER_W-1:0]     rsp_tuser,  // [0] has_bit, [1] status
   output logic                                rsp_tlast
);
   import bae_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type sts;
   logic            out_has_bit;
   logic            out_code_bit;
   follow_type      out_follow;
   logic            out_status;

   bae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bae_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .in_cmd       (req_tuser),
      .in_bit       (req_tdata[0]),
      .in_prob      (req_tdata[PROB_W:1]),
      .cmd          (cmd),
      .sts          (sts),
      .out_ready    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .out_has_bit  (out_has_bit),
      .out_code_bit (out_code_bit),
      .out_follow   (out_follow),
      .out_status   (out_status),
      .out_last     (rsp_tlast)
   );

   // response packing
   assign rsp_tdata = RSP_TDATA_W'({out_follow, out_code_bit});
   assign rsp_tuser = {out_status, out_has_bit};

endmodule

>>> src/bae_checker.sv
// Port-level checker for the arithmetic encoder, bound to the top level.
// Depends on bae_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bae_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [bae_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bae_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [bae_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input logic                            rsp_tlast
);
   import bae_pkg::*;

   // a stalled response stays offered
   `BAE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped")

   // one transaction at a time: busy right after an accept
   `BAE_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "request overlap")

   // error results carry no bit and close the transaction
   `BAE_ASSERT_IMPLY(a_error_shape, rsp_tvalid && rsp_tuser[1], !rsp_tuser[0] && rsp_tlast && rsp_tdata == '0, "bad error result")

   // a result without a bit is always the last one and carries zeros
   `BAE_ASSERT_IMPLY(a_empty_shape, rsp_tvalid && !rsp_tuser[0], rsp_tlast && rsp_tdata == '0, "bad empty result")

endmodule

bind binary_arithmetic_encoder_top bae_checker u_bae_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for binary_arithmetic_encoder_top: a queued stream driver, a
// response monitor and a bit-exact interval coder that predicts every emitted code bit.
// Depends on bae_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_top;
   import bae_pkg::*;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_FLUSH  = 1'b1
   } tb_cmd_type;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_PROB = 1'b1;

   // split points used to squeeze the interval around the half point
   localparam bound_type MID_LOW_AIM  = 16'h7FEF;
   localparam bound_type MID_HIGH_AIM = 16'h8010;
   localparam bound_type NEAR_HALF    = 16'h7F00;

   localparam int RANDOM_SYMBOLS = 210;
   localparam int LONG_HOLD      = 400;

   typedef struct packed {
      bound_type   lo;
      bound_type   hi;
      pending_type pend;
   } coder_type;

   typedef struct packed {
      logic       has_bit;
      logic       code_bit;
      follow_type follow;
      logic       status;
      logic       last;
   } code_out_type;

   typedef struct packed {
      tb_cmd_type cmd;
      logic       sym;
      prob_type   prob;
   } symbol_item_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [0] bit_in, [16:1] prob_zero
   logic                   req_tuser;   // [0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [0] code_bit, [16:1] follow_count
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // [0] has_bit, [1] status
   logic                   rsp_tlast;

   symbol_item_type symbol_queue[$];
   code_out_type    expected_codes[$];
   coder_type       model_state;
   coder_type       plan_state;
   int              error_count;
   int              req_accepted;
   int              hold_trigger;
   int              hold_left;
   bit              hold_done;
   int              calm_left;
   int              gap_left;
   int              stall_left;
   logic            req_fired;

   binary_arithmetic_encoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic coder_type coder_reset_state();
      coder_type st;
      st.lo   = '0;
      st.hi   = BOUND_MAX;
      st.pend = '0;
      return st;
   endfunction

   function automatic pending_type bump_pending(pending_type p);
      return (p == PENDING_MAX) ? p : p + pending_type'(1);
   endfunction

   function automatic follow_type clamp_follow(pending_type p);
      logic [63:0] wide;
      wide = 64'(p);
      return (wide > 64'(FOLLOW_MAX)) ? FOLLOW_MAX : follow_type'(wide);
   endfunction

   // Interval coder: one request in, the code-bit transactions it produces out.
   function automatic int code_symbol(inout coder_type st, input tb_cmd_type cmd,
                                      input logic sym, input prob_type prob,
                                      output code_out_type res [RESULT_LIMIT]);
      logic [31:0] span;
      bound_type   mid;
      logic        top;
      int          n;
      n = 0;
      for (int k = 0; k < RESULT_LIMIT; k++) res[k] = '0;

      if (cmd == CMD_FLUSH) begin
         st.pend = bump_pending(st.pend);
         res[0].has_bit  = 1'b1;
         res[0].code_bit = (st.lo < BOUND_QUARTER) ? 1'b0 : 1'b1;
         res[0].follow   = clamp_follow(st.pend);
         res[0].status   = STATUS_OK;
         res[0].last     = 1'b1;
         st = coder_reset_state();
         return 1;
      end

      if (prob == '0) begin
         res[0].status = STATUS_BAD_PROB;
         res[0].last   = 1'b1;
         return 1;
      end

      // split the interval
      span = 32'(bound_type'(st.hi - st.lo));
      mid  = bound_type'(32'(st.lo) + ((32'(prob) * span) >> PROB_W));
      if (sym) st.lo = mid + bound_type'(1);
      else     st.hi = mid;

      // renormalize: halvings emit, middle scalings defer
      while (n < RESULT_LIMIT) begin
         top = st.hi[PRECISION_BITS-1];
         if (top == st.lo[PRECISION_BITS-1]) begin
            st.hi = {st.hi[PRECISION_BITS-2:0], 1'b1};
            st.lo = {st.lo[PRECISION_BITS-2:0], 1'b0};
            res[n].has_bit  = 1'b1;
            res[n].code_bit = top;
            res[n].follow   = clamp_follow(st.pend);
            res[n].status   = STATUS_OK;
            n++;
            st.pend = '0;
         end else if (st.lo > BOUND_QUARTER && st.hi <= BOUND_3QUARTERS) begin
            st.hi = st.hi - QUARTER_STEP;
            st.lo = st.lo - QUARTER_STEP;
            st.hi = {st.hi[PRECISION_BITS-2:0], 1'b1};
            st.lo = {st.lo[PRECISION_BITS-2:0], 1'b0};
            st.pend = bump_pending(st.pend);
         end else begin
            break;
         end
      end

      if (n == 0) begin
         res[0].status = STATUS_OK;
         res[0].last   = 1'b1;
         return 1;
      end
      res[n-1].last = 1'b1;
      return n;
   endfunction

   // probability that puts the split point at (or just under) target
   function automatic prob_type aim_prob(coder_type st, bound_type target);
      logic [31:0] span;
      logic [31:0] p;
      span = 32'(bound_type'(st.hi - st.lo));
      if (target <= st.lo || span == 0) return prob_type'(1);
      p = (32'(bound_type'(target - st.lo)) << PROB_W) / span;
      if (p == 0)     p = 1;
      if (p > 65535)  p = 65535;
      return prob_type'(p);
   endfunction

   // short gaps mostly, now and then a long one; none during calm stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_left > 0) return 0;
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_item(tb_cmd_type cmd, logic sym, prob_type prob);
      symbol_item_type it;
      code_out_type    scratch [RESULT_LIMIT];
      int              n;
      it.cmd  = cmd;
      it.sym  = sym;
      it.prob = prob;
      symbol_queue.push_back(it);
      n = code_symbol(plan_state, cmd, sym, prob, scratch);
   endtask

   // one item of a pair: park low just under half, or, once low is near half, pull high just over it
   task automatic queue_squeeze();
      if (plan_state.lo < NEAR_HALF)
         queue_item(CMD_ENCODE, 1'b1, aim_prob(plan_state, MID_LOW_AIM));
      else
         queue_item(CMD_ENCODE, 1'b0, aim_prob(plan_state, MID_HIGH_AIM));
   endtask

   // calm stretches: no idling on either side
   always @(negedge clock) begin
      if (calm_left > 0)
         calm_left <= calm_left - 1;
      else if ($urandom_range(0, 399) == 0)
         calm_left <= $urandom_range(80, 250);
   end

   // long receiver hold-off, once, partway into the random traffic
   always @(negedge clock) begin
      if (!hold_done && req_accepted >= hold_trigger) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // request driver
   always @(negedge clock) begin : driver
      symbol_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left   <= gap_left - 1;
         end else if (symbol_queue.size() > 0) begin
            it = symbol_queue.pop_front();
            req_tdata  <= {{(REQ_TDATA_W - 1 - PROB_W){1'b0}}, it.prob, it.sym};
            req_tuser  <= it.cmd;
            req_tvalid <= 1'b1;
            gap_left   <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready with random stalls
   always @(negedge clock) begin
      if (reset || hold_left > 0) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin : monitor
      code_out_type res [RESULT_LIMIT];
      code_out_type exp_code;
      code_out_type got;
      int           n;
      req_fired <= req_tvalid & req_tready;

      if (!reset && req_tvalid && req_tready) begin
         req_accepted <= req_accepted + 1;
         n = code_symbol(model_state, tb_cmd_type'(req_tuser), req_tdata[0],
                         req_tdata[PROB_W:1], res);
         for (int k = 0; k < n; k++) expected_codes.push_back(res[k]);
      end

      if (!reset && rsp_tvalid && rsp_tready) begin
         got.has_bit  = rsp_tuser[0];
         got.code_bit = rsp_tdata[0];
         got.follow   = rsp_tdata[FOLLOW_W:1];
         got.status   = rsp_tuser[1];
         got.last     = rsp_tlast;
         if (expected_codes.size() == 0) begin
            $error("response transaction with nothing expected");
            error_count++;
         end else begin
            exp_code = expected_codes.pop_front();
            if (got.has_bit !== exp_code.has_bit) begin
               $error("has_bit: expected %0d, got %0d", exp_code.has_bit, got.has_bit);
               error_count++;
            end
            if (got.code_bit !== exp_code.code_bit) begin
               $error("code_bit: expected %0d, got %0d", exp_code.code_bit, got.code_bit);
               error_count++;
            end
            if (got.follow !== exp_code.follow) begin
               $error("follow_count: expected %0d, got %0d", exp_code.follow, got.follow);
               error_count++;
            end
            if (got.status !== exp_code.status) begin
               $error("status: expected %0d, got %0d", exp_code.status, got.status);
               error_count++;
            end
            if (got.last !== exp_code.last) begin
               $error("last: expected %0d, got %0d", exp_code.last, got.last);
               error_count++;
            end
         end
      end
   end

   // Overall limit. The slowest legal run is about 230 requests, each with at
   // most one gap from pick_gap, its time in the block and up to 17 results each
   // waiting out a stall, plus the LONG_HOLD hold-off: about 2M ns; this
   // allows several times that.
   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus and end of test
   initial begin : stimulus
      int       r;
      prob_type p;
      logic     s;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      rsp_tready   = 1'b0;
      req_fired    = 1'b0;
      error_count  = 0;
      req_accepted = 0;
      hold_trigger = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      calm_left    = 0;
      gap_left     = 0;
      stall_left   = 0;
      model_state  = coder_reset_state();
      plan_state   = coder_reset_state();

      // directed: extremes, errors, flush on both sides of the quarter point
      queue_item(CMD_FLUSH,  1'b0, 16'h0000);   // flush from reset, low below quarter
      queue_item(CMD_ENCODE, 1'b0, 16'h0000);   // zero probability
      queue_item(CMD_ENCODE, 1'b1, 16'h0000);
      queue_item(CMD_ENCODE, 1'b0, 16'h0001);   // interval collapses: sixteen zeros
      queue_item(CMD_ENCODE, 1'b1, 16'hFFFF);   // sixteen ones
      queue_item(CMD_ENCODE, 1'b0, 16'hFFFF);   // no bit emitted
      queue_item(CMD_ENCODE, 1'b1, 16'h0001);
      queue_item(CMD_ENCODE, 1'b1, 16'hAAAA);
      queue_item(CMD_ENCODE, 1'b0, 16'h5555);
      queue_item(CMD_FLUSH,  1'b1, 16'hFFFF);
      queue_item(CMD_ENCODE, 1'b1, 16'h6000);
      queue_item(CMD_FLUSH,  1'b0, 16'h1234);   // low above quarter -> bit 1
      queue_squeeze();                          // middle scalings build pending
      queue_squeeze();
      queue_item(CMD_ENCODE, 1'b1, 16'h0000);   // error must keep the pending count
      queue_item(CMD_ENCODE, 1'b0, 16'h8000);   // emits with follow bits
      queue_squeeze();
      queue_squeeze();
      queue_item(CMD_FLUSH,  1'b1, 16'h0000);   // flush with pending count

      hold_trigger = symbol_queue.size() + 60;

      // random traffic
      for (int i = 0; i < RANDOM_SYMBOLS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            queue_item(CMD_FLUSH, 1'($urandom_range(0, 1)), prob_type'($urandom));
         end else if (r < 13) begin
            queue_item(CMD_ENCODE, 1'($urandom_range(0, 1)), '0);
         end else begin
            case ($urandom_range(0, 7))
               0: p = 16'h0001;
               1: p = 16'hFFFF;
               2: p = prob_type'($urandom_range(1, 15));
               3: p = prob_type'($urandom_range(65520, 65535));
               default: p = prob_type'($urandom_range(1, 65535));
            endcase
            // half the symbols follow the stated probability, half are coin flips
            if ($urandom_range(0, 1)) s = ($urandom_range(0, 65535) >= p);
            else                      s = 1'($urandom_range(0, 1));
            queue_item(CMD_ENCODE, s, p);
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (symbol_queue.size() == 0 && !req_tvalid);
      wait (expected_codes.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/bae_pkg.sv
src/bae_ctrl.sv
src/bae_datapath.sv
src/binary_arithmetic_encoder_top.sv
src/bae_checker.sv
test/tb_top.sv
